// ----- rtl/core/dcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dcm_pkg;

  // Default datapath widths
  localparam int STATE_WIDTH_DEF = 48;
  localparam int COEF_WIDTH_DEF  = 32;

  // Drive voltage format: signed Q8.8
  localparam int VOLT_WIDTH = 16;
  localparam int VOLT_FRAC  = 8;

  // Configuration register file
  localparam int NUM_REGS  = 6;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STEP_SIZE       = 3'd0,
    REG_SPEED_SELF_GAIN = 3'd1,
    REG_TORQUE_GAIN     = 3'd2,
    REG_BACK_EMF_GAIN   = 3'd3,
    REG_RESISTIVE_GAIN  = 3'd4,
    REG_DRIVE_GAIN      = 3'd5
  } reg_index_t;

  // Reset values of the coefficients, Q2.30 at the default width
  localparam longint STEP_SIZE_RST       = 64'd107374;
  localparam longint SPEED_SELF_GAIN_RST = 64'd107374;
  localparam longint TORQUE_GAIN_RST     = 64'd228359116;
  localparam longint BACK_EMF_GAIN_RST   = 64'd39400957;
  localparam longint RESISTIVE_GAIN_RST  = 64'd390095774;
  localparam longint DRIVE_GAIN_RST      = 64'd1304668256;

endpackage

`default_nettype wire

// ----- rtl/core/dcm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Drive channel: one beat per simulation step
interface dcm_drive_if import dcm_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VOLT_WIDTH-1:0] voltage;

  modport source (output valid, output voltage, input ready);
  modport sink   (input valid, input voltage, output ready);
endinterface

// Result channel: motor state at the start of a step
interface dcm_result_if import dcm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [STATE_WIDTH-1:0] angle_out;
  logic signed [STATE_WIDTH-1:0] speed_out;
  logic signed [STATE_WIDTH-1:0] current_out;

  modport source (output valid, output angle_out, output speed_out, output current_out,
                  input ready);
  modport sink   (input valid, input angle_out, input speed_out, input current_out,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dcm_prod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Exact signed coefficient times state product, built from two partial
// products over the signed upper and unsigned lower halves of the state.
module dcm_prod import dcm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic signed [COEF_WIDTH-1:0]             coef,
  input  logic signed [STATE_WIDTH-1:0]            state,
  output logic signed [STATE_WIDTH+COEF_WIDTH-1:0] product
);

  localparam int LO_W   = STATE_WIDTH / 2;
  localparam int HI_W   = STATE_WIDTH - LO_W;
  localparam int PROD_W = STATE_WIDTH + COEF_WIDTH;
  localparam int PLO_W  = COEF_WIDTH + LO_W + 1;

  logic signed [HI_W-1:0]            state_hi;
  logic signed [LO_W:0]              state_lo;
  logic signed [COEF_WIDTH+HI_W-1:0] pp_hi;
  logic signed [PLO_W-1:0]           pp_lo;

  // Split the state word
  assign state_hi = state[STATE_WIDTH-1:LO_W];
  assign state_lo = $signed({1'b0, state[LO_W-1:0]});

  // Partial products
  assign pp_hi = coef * state_hi;
  assign pp_lo = coef * state_lo;

  // Align and combine
  assign product = $signed({pp_hi, {LO_W{1'b0}}})
                 + $signed({{(PROD_W-PLO_W){pp_lo[PLO_W-1]}}, pp_lo});

endmodule

`default_nettype wire

// ----- rtl/core/dcm_sat.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Round an accumulated sum half up to the state format and clamp it to the
// state range.
module dcm_sat import dcm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
  parameter int ACC_WIDTH   = STATE_WIDTH + COEF_WIDTH + 3
) (
  input  logic signed [ACC_WIDTH-1:0]   acc,
  output logic signed [STATE_WIDTH-1:0] state_next
);

  localparam int COEF_FRAC = COEF_WIDTH - 2;
  localparam int TOP_LSB   = COEF_FRAC + STATE_WIDTH - 1;
  localparam logic [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);
  localparam logic [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  logic [ACC_WIDTH-1:0] rounded;
  logic                 fits;

  // Add half an LSB of the state format
  assign rounded = acc + HALF;

  // In range when the bits above the state sign all match it
  assign fits = (&rounded[ACC_WIDTH-1:TOP_LSB]) || !(|rounded[ACC_WIDTH-1:TOP_LSB]);

  // Drop the fraction, or clamp by the sign
  always_comb begin
    if (fits) begin
      state_next = $signed(rounded[TOP_LSB:COEF_FRAC]);
    end else if (rounded[ACC_WIDTH-1]) begin
      state_next = $signed(STATE_MIN);
    end else begin
      state_next = $signed(STATE_MAX);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dc_motor_euler_step_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                 Beat
// drive    in   voltage (Q8.8)                         one simulation step
// result   out  angle_out, speed_out, current_out      state before the step
// cfg      in   cfg_write, cfg_index, cfg_data         one coefficient write
//
// One step per clock unless stalled: the forward-Euler update runs from the state
// registers through the coefficient products and one adder row into the state
// registers. A beat is answered from the result register in the cycle after
// acceptance. Drive is taken while the result register is empty or being drained.
// Reset clears the state to zero and loads the default coefficients.
module dc_motor_euler_step_core import dcm_pkg::*; #(
  parameter int STATE_WIDTH = STATE_WIDTH_DEF,
  parameter int COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  dcm_drive_if.sink                  drive,
  dcm_result_if.source               result,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COEF_WIDTH-1:0]      cfg_data
);

  localparam int STATE_FRAC = STATE_WIDTH / 2;
  localparam int COEF_FRAC  = COEF_WIDTH - 2;
  localparam int PROD_W     = STATE_WIDTH + COEF_WIDTH;
  localparam int VPROD_W    = COEF_WIDTH + VOLT_WIDTH;
  localparam int ACC_W      = STATE_WIDTH + COEF_WIDTH + 3;
  localparam int VOLT_SHIFT = STATE_FRAC - VOLT_FRAC;

  logic signed [COEF_WIDTH-1:0]  step_size;
  logic signed [COEF_WIDTH-1:0]  speed_self_gain;
  logic signed [COEF_WIDTH-1:0]  torque_gain;
  logic signed [COEF_WIDTH-1:0]  back_emf_gain;
  logic signed [COEF_WIDTH-1:0]  resistive_gain;
  logic signed [COEF_WIDTH-1:0]  drive_gain;

  logic signed [STATE_WIDTH-1:0] angle;
  logic signed [STATE_WIDTH-1:0] speed;
  logic signed [STATE_WIDTH-1:0] current;
  logic signed [STATE_WIDTH-1:0] angle_next;
  logic signed [STATE_WIDTH-1:0] speed_next;
  logic signed [STATE_WIDTH-1:0] current_next;

  logic signed [PROD_W-1:0]      p_angle_speed;
  logic signed [PROD_W-1:0]      p_speed_speed;
  logic signed [PROD_W-1:0]      p_speed_current;
  logic signed [PROD_W-1:0]      p_current_speed;
  logic signed [PROD_W-1:0]      p_current_current;
  logic signed [VPROD_W-1:0]     p_voltage;

  logic signed [ACC_W-1:0]       acc_angle;
  logic signed [ACC_W-1:0]       acc_speed;
  logic signed [ACC_W-1:0]       acc_current;

  logic                          out_valid;
  logic                          accept;

  // Coefficient writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= COEF_WIDTH'(STEP_SIZE_RST);
      speed_self_gain <= COEF_WIDTH'(SPEED_SELF_GAIN_RST);
      torque_gain     <= COEF_WIDTH'(TORQUE_GAIN_RST);
      back_emf_gain   <= COEF_WIDTH'(BACK_EMF_GAIN_RST);
      resistive_gain  <= COEF_WIDTH'(RESISTIVE_GAIN_RST);
      drive_gain      <= COEF_WIDTH'(DRIVE_GAIN_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_SIZE:       step_size       <= $signed(cfg_data);
        REG_SPEED_SELF_GAIN: speed_self_gain <= $signed(cfg_data);
        REG_TORQUE_GAIN:     torque_gain     <= $signed(cfg_data);
        REG_BACK_EMF_GAIN:   back_emf_gain   <= $signed(cfg_data);
        REG_RESISTIVE_GAIN:  resistive_gain  <= $signed(cfg_data);
        REG_DRIVE_GAIN:      drive_gain      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Coefficient products on the old state
  dcm_prod #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_prod_as (
    .coef(step_size), .state(speed), .product(p_angle_speed)
  );
  dcm_prod #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_prod_ss (
    .coef(speed_self_gain), .state(speed), .product(p_speed_speed)
  );
  dcm_prod #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_prod_sc (
    .coef(torque_gain), .state(current), .product(p_speed_current)
  );
  dcm_prod #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_prod_cs (
    .coef(back_emf_gain), .state(speed), .product(p_current_speed)
  );
  dcm_prod #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_prod_cc (
    .coef(resistive_gain), .state(current), .product(p_current_current)
  );

  assign p_voltage = drive_gain * drive.voltage;

  // Exact sums at the product scale
  assign acc_angle   = ACC_W'($signed({angle, {COEF_FRAC{1'b0}}}))
                     + ACC_W'(p_angle_speed);
  assign acc_speed   = ACC_W'($signed({speed, {COEF_FRAC{1'b0}}}))
                     + ACC_W'(p_speed_speed)
                     + ACC_W'(p_speed_current);
  assign acc_current = ACC_W'($signed({current, {COEF_FRAC{1'b0}}}))
                     - ACC_W'(p_current_speed)
                     - ACC_W'(p_current_current)
                     + (ACC_W'(p_voltage) <<< VOLT_SHIFT);

  // Round and clamp each new state value
  dcm_sat #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(ACC_W))
    u_sat_angle (.acc(acc_angle), .state_next(angle_next));
  dcm_sat #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(ACC_W))
    u_sat_speed (.acc(acc_speed), .state_next(speed_next));
  dcm_sat #(.STATE_WIDTH(STATE_WIDTH), .COEF_WIDTH(COEF_WIDTH), .ACC_WIDTH(ACC_W))
    u_sat_current (.acc(acc_current), .state_next(current_next));

  // Take a drive beat whenever the result register can move
  assign drive.ready = !out_valid || result.ready;
  assign accept      = drive.valid && drive.ready;

  // Advance the motor state one step per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      angle   <= '0;
      speed   <= '0;
      current <= '0;
    end else if (accept) begin
      angle   <= angle_next;
      speed   <= speed_next;
      current <= current_next;
    end
  end

  // Result register: hold until drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.angle_out   <= angle;
      result.speed_out   <= speed;
      result.current_out <= current;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire
